// ----- rtl/fcrc_pkg.sv -----
package fcrc_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_CHECK_MODE = 1'b0,
        CFG_EXP_LENGTH = 1'b1
    } fcrc_cfg_idx_t;

    // Delimiter bytes that must not appear in a transmitted CRC
    localparam logic [7:0] ESC_OPEN_PAREN = 8'h28;
    localparam logic [7:0] ESC_CR         = 8'h0D;
    localparam logic [7:0] ESC_LF         = 8'h0A;

    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [7:0] TRAILER_BYTES  = 8'd3;

    // Result of one frame
    typedef struct packed {
        logic [15:0] crc_value;
        logic        crc_ok;
        logic        length_ok;
        logic        too_short;
    } fcrc_result_t;

    // Nibble table for polynomial 0x1021
    function automatic logic [15:0] nib_tab(input logic [3:0] idx);
        logic [15:0] val;
        case (idx)
            4'h0: val = 16'h0000;
            4'h1: val = 16'h1021;
            4'h2: val = 16'h2042;
            4'h3: val = 16'h3063;
            4'h4: val = 16'h4084;
            4'h5: val = 16'h50a5;
            4'h6: val = 16'h60c6;
            4'h7: val = 16'h70e7;
            4'h8: val = 16'h8108;
            4'h9: val = 16'h9129;
            4'hA: val = 16'ha14a;
            4'hB: val = 16'hb16b;
            4'hC: val = 16'hc18c;
            4'hD: val = 16'hd1ad;
            4'hE: val = 16'he1ce;
            4'hF: val = 16'hf1ef;
            default: val = 16'h0000;
        endcase
        return val;
    endfunction

    function automatic logic [15:0] crc_nibble(input logic [15:0] c, input logic [3:0] nib);
        return {c[11:0], 4'h0} ^ nib_tab(c[15:12] ^ nib);
    endfunction

    // High nibble first
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        return crc_nibble(crc_nibble(c, b[7:4]), b[3:0]);
    endfunction

    function automatic logic [7:0] escape_byte(input logic [7:0] b);
        if (b == ESC_OPEN_PAREN || b == ESC_CR || b == ESC_LF) begin
            return b + 8'd1;
        end
        return b;
    endfunction

endpackage

// ----- rtl/frame_crc16_escaped_check_top.sv -----
// Channel  | Direction | Handshake           | Payload
// s_       | in        | s_valid / s_ready   | s_data_byte[7:0], s_frame_end
// m_       | out       | m_valid / m_ready   | m_crc_value[15:0], m_crc_ok, m_length_ok,
//          |           |                     | m_too_short
// cfg_     | in        | cfg_we (no wait)    | cfg_index[0], cfg_wdata[7:0]
//
// One byte per cycle sustained while results are taken: a byte is held in the input
// register, then the CRC engine (two nibble table steps) updates the frame state.
// A frame result appears on m_ after its last byte has passed the input register and the result register.
// Synchronous active-low reset clears the frame state, configuration and both valids.
// A stalled result only holds back a later frame-end byte and the bytes behind it; bytes before it keep flowing.
module frame_crc16_escaped_check_top
    import fcrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_crc_value,
    output logic        m_crc_ok,
    output logic        m_length_ok,
    output logic        m_too_short,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic         check_mode_reg;
    logic [7:0]   exp_len_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    fcrc_result_t out_reg;
    fcrc_result_t result;
    logic         out_free;
    logic         advance;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_mode_reg <= 1'b0;
            exp_len_reg    <= '0;
        end else if (cfg_we) begin
            case (fcrc_cfg_idx_t'(cfg_index))
                CFG_CHECK_MODE: check_mode_reg <= cfg_wdata[0];
                CFG_EXP_LENGTH: exp_len_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the held item unless it ends a frame and the result slot is full and not being read
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_frame_end;
        end
    end

    fcrc_engine u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .data_byte       (in_byte_reg),
        .frame_end       (in_last_reg),
        .check_mode      (check_mode_reg),
        .expected_length (exp_len_reg),
        .result          (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= result;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_crc_value = out_reg.crc_value;
    assign m_crc_ok    = out_reg.crc_ok;
    assign m_length_ok = out_reg.length_ok;
    assign m_too_short = out_reg.too_short;

endmodule

// ----- rtl/fcrc_engine.sv -----
module fcrc_engine
    import fcrc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         advance,
    input  logic [7:0]   data_byte,
    input  logic         frame_end,
    input  logic         check_mode,
    input  logic [7:0]   expected_length,
    output fcrc_result_t result
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  dly0_reg, dly1_reg, dly2_reg;
    logic [7:0]  dly0_next, dly1_next, dly2_next;
    logic [7:0]  count_reg, count_next;

    logic [15:0] crc_upd;
    logic [7:0]  count_inc;
    logic [7:0]  hi_esc, lo_esc;
    logic        short_frame;

    // Fold a byte into the CRC: the input in generate mode, the full delay tail in check mode
    always_comb begin
        if (!check_mode) begin
            crc_upd = crc_byte(crc_reg, data_byte);
        end else if (count_reg >= TRAILER_BYTES) begin
            crc_upd = crc_byte(crc_reg, dly2_reg);
        end else begin
            crc_upd = crc_reg;
        end
        count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 8'd1;
    end

    // Escape the CRC bytes and build the frame result
    always_comb begin
        hi_esc      = escape_byte(crc_upd[15:8]);
        lo_esc      = escape_byte(crc_upd[7:0]);
        short_frame = count_inc < TRAILER_BYTES;
        result.crc_value = {hi_esc, lo_esc};
        result.too_short = check_mode && short_frame;
        result.crc_ok    = check_mode && !short_frame
                           && hi_esc == dly1_reg && lo_esc == dly0_reg;
        result.length_ok = check_mode && !short_frame
                           && (count_inc - TRAILER_BYTES) == expected_length;
    end

    // Advance state, or clear it at the end of a frame
    always_comb begin
        crc_next   = crc_reg;
        dly0_next  = dly0_reg;
        dly1_next  = dly1_reg;
        dly2_next  = dly2_reg;
        count_next = count_reg;
        if (advance) begin
            if (frame_end) begin
                crc_next   = '0;
                dly0_next  = '0;
                dly1_next  = '0;
                dly2_next  = '0;
                count_next = '0;
            end else begin
                crc_next   = crc_upd;
                dly0_next  = data_byte;
                dly1_next  = dly0_reg;
                dly2_next  = dly1_reg;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= '0;
            dly0_reg  <= '0;
            dly1_reg  <= '0;
            dly2_reg  <= '0;
            count_reg <= '0;
        end else begin
            crc_reg   <= crc_next;
            dly0_reg  <= dly0_next;
            dly1_reg  <= dly1_next;
            dly2_reg  <= dly2_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/fcrc_checker.sv -----
module fcrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_data_byte,
    input logic        s_frame_end,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_crc_value,
    input logic        m_crc_ok,
    input logic        m_length_ok,
    input logic        m_too_short,
    input logic        cfg_we,
    input logic [0:0]  cfg_index,
    input logic [7:0]  cfg_wdata
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_crc_value)
        && $stable(m_crc_ok) && $stable(m_length_ok) && $stable(m_too_short))
        else $error("stalled result changed");

    // Drop the result valid after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A short frame reports no match
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_short |-> !m_crc_ok && !m_length_ok)
        else $error("short frame flagged as matching");

    // A short frame has covered no bytes, so its CRC is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_short |-> m_crc_value == 16'h0000)
        else $error("short frame with non-zero CRC");

endmodule

bind frame_crc16_escaped_check_top fcrc_checker u_fcrc_checker (.*);
